[hw/rtl/pcfm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pump current fault monitor package
// Shared item types, command and state codes, and configuration bundle.
// ----------------------------------------------------------------------------
package pcfm_pkg;

  // Command codes carried in the func field
  localparam logic [2:0] FUNC_SAMPLE = 3'd0;
  localparam logic [2:0] FUNC_CLEAR  = 3'd1;
  localparam logic [2:0] FUNC_ON     = 3'd2;
  localparam logic [2:0] FUNC_OFF    = 3'd3;
  localparam logic [2:0] FUNC_TOGGLE = 3'd4;
  localparam logic [2:0] FUNC_RESET  = 3'd5;

  // Pump state codes
  localparam logic [2:0] ST_OFF  = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_HIGH = 3'd2;
  localparam logic [2:0] ST_DRY  = 3'd3;
  localparam logic [2:0] ST_CRIT = 3'd4;
  localparam logic [2:0] ST_OVL  = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_PUMP_MODE      = 3'd0;
  localparam logic [2:0] CFG_THRESH_OFF     = 3'd1;
  localparam logic [2:0] CFG_THRESH_NOWATER = 3'd2;
  localparam logic [2:0] CFG_THRESH_RUNNING = 3'd3;
  localparam logic [2:0] CFG_THRESH_OVL     = 3'd4;
  localparam logic [2:0] CFG_CRIT_PERCENT   = 3'd5;
  localparam logic [2:0] CFG_DRY_TIMEOUT    = 3'd6;
  localparam logic [2:0] CFG_OVL_TIMEOUT    = 3'd7;

  // Timer armed bit positions
  localparam int unsigned ARM_DRY  = 0;
  localparam int unsigned ARM_CRIT = 1;
  localparam int unsigned ARM_OVL  = 2;

  // Critical threshold is running threshold times percent over CritScale
  localparam int unsigned CritScale = 100;
  localparam int unsigned ProdW     = 24;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] current_ma;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] pump_state;
    logic       relay_on;
    logic       fault_latched;
    logic       event_res;
  } out_item_t;

  typedef struct packed {
    logic             pump_mode;
    logic [15:0]      thresh_off_ma;
    logic [15:0]      thresh_no_water_ma;
    logic [15:0]      thresh_running_ma;
    logic [15:0]      thresh_overload_ma;
    logic [7:0]       critical_percent;
    logic [15:0]      dry_timeout_ms;
    logic [15:0]      overload_timeout_ms;
    logic [ProdW-1:0] crit_prod;  // thresh_running_ma * critical_percent
  } cfg_t;

  function automatic logic is_fault(logic [2:0] st);
    is_fault = (st == ST_DRY) || (st == ST_CRIT) || (st == ST_OVL);
  endfunction

endpackage

[hw/rtl/pcfm_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pump current fault monitor configuration registers
// Holds the thresholds and timeouts and the running-times-percent product.
// ----------------------------------------------------------------------------
module pcfm_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i,
  output pcfm_pkg::cfg_t cfg_o
);
  import pcfm_pkg::*;

  cfg_t cfg_q;

  // Refresh the product on the write that changes one of its factors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pump_mode           <= 1'b1;
      cfg_q.thresh_off_ma       <= 16'd50;
      cfg_q.thresh_no_water_ma  <= 16'd200;
      cfg_q.thresh_running_ma   <= 16'd2000;
      cfg_q.thresh_overload_ma  <= 16'd5000;
      cfg_q.critical_percent    <= 8'd120;
      cfg_q.dry_timeout_ms      <= 16'd5000;
      cfg_q.overload_timeout_ms <= 16'd1000;
      cfg_q.crit_prod           <= ProdW'(2000 * 120);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PUMP_MODE:      cfg_q.pump_mode <= cfg_wdata_i[0];
        CFG_THRESH_OFF:     cfg_q.thresh_off_ma <= cfg_wdata_i;
        CFG_THRESH_NOWATER: cfg_q.thresh_no_water_ma <= cfg_wdata_i;
        CFG_THRESH_RUNNING: begin
          cfg_q.thresh_running_ma <= cfg_wdata_i;
          cfg_q.crit_prod <= ProdW'(cfg_wdata_i) * ProdW'(cfg_q.critical_percent);
        end
        CFG_THRESH_OVL:     cfg_q.thresh_overload_ma <= cfg_wdata_i;
        CFG_CRIT_PERCENT: begin
          cfg_q.critical_percent <= cfg_wdata_i[7:0];
          cfg_q.crit_prod <= ProdW'(cfg_q.thresh_running_ma) * ProdW'(cfg_wdata_i[7:0]);
        end
        CFG_DRY_TIMEOUT:    cfg_q.dry_timeout_ms <= cfg_wdata_i;
        CFG_OVL_TIMEOUT:    cfg_q.overload_timeout_ms <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/pcfm_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pump current fault monitor core
// Classifies one sample against the thresholds or applies one command, and holds the monitor state.
// ----------------------------------------------------------------------------
module pcfm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  pcfm_pkg::in_item_t  item_i,
  input  pcfm_pkg::cfg_t      cfg_i,
  output pcfm_pkg::out_item_t result_o
);
  import pcfm_pkg::*;

  logic [2:0]  state_q, state_d;
  logic        latch_q, latch_d;
  logic        relay_q, relay_d;
  logic [2:0]  armed_q, armed_d;
  logic [31:0] dry_since_q, dry_since_d;
  logic [31:0] crit_since_q, crit_since_d;
  logic [31:0] ovl_since_q, ovl_since_d;

  logic [2:0]       next_st;
  logic             ev;
  logic [ProdW-1:0] cur_x100;
  logic             crit_hit;
  logic             ovl_due, crit_due, dry_due;
  logic [15:0]      cur;
  logic [31:0]      now;

  assign cur = item_i.current_ma;
  assign now = item_i.time_ms;

  // cur >= floor(prod / 100)  <=>  100 * cur + 99 >= prod
  assign cur_x100 = (ProdW'(cur) << 6) + (ProdW'(cur) << 5) + (ProdW'(cur) << 2);
  assign crit_hit = (cur_x100 + ProdW'(CritScale - 1)) >= cfg_i.crit_prod;

  assign ovl_due  = (now - ovl_since_q)  >= {16'd0, cfg_i.overload_timeout_ms};
  assign crit_due = (now - crit_since_q) >= {16'd0, cfg_i.dry_timeout_ms};
  assign dry_due  = (now - dry_since_q)  >= {16'd0, cfg_i.dry_timeout_ms};

  always_comb begin
    state_d      = state_q;
    latch_d      = latch_q;
    relay_d      = relay_q;
    armed_d      = armed_q;
    dry_since_d  = dry_since_q;
    crit_since_d = crit_since_q;
    ovl_since_d  = ovl_since_q;
    next_st      = state_q;
    ev           = 1'b0;
    unique case (item_i.func) inside
      FUNC_SAMPLE: begin
        if (!latch_q) begin
          if (cur < cfg_i.thresh_off_ma) begin
            next_st = ST_OFF;
            armed_d = '0;
          end else if (cur >= cfg_i.thresh_overload_ma) begin
            if (armed_q[ARM_OVL]) begin
              if (ovl_due) next_st = ST_OVL;
            end else begin
              ovl_since_d = now;
            end
            armed_d = '0;
            armed_d[ARM_OVL] = 1'b1;
          end else if (!cfg_i.pump_mode) begin
            next_st = ST_RUN;
            armed_d = '0;
          end else if (crit_hit) begin
            if (armed_q[ARM_CRIT]) begin
              if (crit_due) next_st = ST_CRIT;
            end else begin
              crit_since_d = now;
            end
            armed_d = '0;
            armed_d[ARM_CRIT] = 1'b1;
          end else if (cur >= cfg_i.thresh_running_ma) begin
            next_st = ST_HIGH;
            armed_d = '0;
          end else if (cur < cfg_i.thresh_no_water_ma) begin
            if (armed_q[ARM_DRY]) begin
              if (dry_due) next_st = ST_DRY;
            end else begin
              dry_since_d = now;
            end
            armed_d = '0;
            armed_d[ARM_DRY] = 1'b1;
          end else begin
            next_st = ST_RUN;
            armed_d = '0;
          end
          // Hold everything but the timers when the state does not move
          if (next_st != state_q) begin
            state_d = next_st;
            latch_d = is_fault(next_st);
            if (is_fault(next_st)) relay_d = 1'b0;
            ev = 1'b1;
          end
        end
      end
      FUNC_CLEAR: begin
        latch_d = 1'b0;
        armed_d = '0;
        if (is_fault(state_q)) begin
          state_d = ST_OFF;
          ev      = 1'b1;
        end
      end
      FUNC_ON, FUNC_OFF, FUNC_TOGGLE: begin
        relay_d = (item_i.func == FUNC_TOGGLE) ? !relay_q : (item_i.func == FUNC_ON);
        latch_d = 1'b0;
        ev      = 1'b1;
      end
      FUNC_RESET: begin
        state_d = ST_OFF;
        latch_d = 1'b0;
        armed_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_OFF;
      latch_q <= 1'b0;
      relay_q <= 1'b0;
      armed_q <= '0;
    end else if (en_i) begin
      state_q <= state_d;
      latch_q <= latch_d;
      relay_q <= relay_d;
      armed_q <= armed_d;
    end
  end

  // Start times are only read while their armed bit is set
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dry_since_q  <= dry_since_d;
      crit_since_q <= crit_since_d;
      ovl_since_q  <= ovl_since_d;
    end
  end

  assign result_o.pump_state    = state_d;
  assign result_o.relay_on      = relay_d;
  assign result_o.fault_latched = latch_d;
  assign result_o.event_res     = ev;

  a_one_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(armed_q))
    else $error("more than one persistence timer armed");

  a_latch_relay_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q |-> !relay_q)
    else $error("fault latched while relay on");

  a_latch_fault_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q |-> (state_q == ST_DRY || state_q == ST_CRIT || state_q == ST_OVL))
    else $error("fault latched outside a fault state");

endmodule

[hw/rtl/pump_current_fault_monitor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pump current fault monitor
// Classifies current samples and commands into a pump state, relay and latch.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle unless the input stalls, and each item
// produces exactly one result transfer, in order. An input register feeds
// the classifier, which updates the monitor state and loads the result
// register in the same cycle. While a finished result waits for the
// output side, the input register takes one more item and then stalls
// the input until the result drains. Configuration writes are registered,
// including the critical-threshold product, so an item may follow a write on
// the very next cycle.
module pump_current_fault_monitor_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pcfm_pkg::in_item_t  in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcfm_pkg::out_item_t out_data_o
);
  import pcfm_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  out_item_t result;
  logic      out_valid_q;
  logic      in_xfer;
  logic      load_out;

  pcfm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Advance the held item when the result register is free or draining
  assign load_out   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !load_out;
  assign in_xfer    = in_valid_i && !in_stall_o;

  pcfm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (load_out),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (load_out) begin
        in_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_xfer) in_q <= in_data_i;
    if (load_out) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  a_latch_means_relay_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fault_latched) |-> !out_data_o.relay_on)
    else $error("result shows latched fault with relay on");

  a_result_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_o)
    else $error("advanced item produced no result");

endmodule

[sim/pcfm_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pump current fault monitor scoreboard
// Predicts the status transfer of every accepted item and checks the
// transfers that come out of the monitor, in order.
// ----------------------------------------------------------------------------
package pcfm_scoreboard_pkg;
  import pcfm_pkg::*;

  class pump_status_scoreboard;
    // register copy
    logic        pump_mode;
    logic [15:0] thresh_off;
    logic [15:0] thresh_no_water;
    logic [15:0] thresh_running;
    logic [15:0] thresh_overload;
    logic [7:0]  crit_percent;
    logic [15:0] dry_timeout;
    logic [15:0] overload_timeout;
    // monitor state
    logic [2:0]  pump_state;
    logic        latched;
    logic        relay;
    logic [31:0] dry_start;
    logic [31:0] crit_start;
    logic [31:0] ovl_start;
    logic [2:0]  armed;
    out_item_t   expected_status[$];
    int unsigned mismatches;

    function new();
      pump_mode        = 1'b1;
      thresh_off       = 16'd50;
      thresh_no_water  = 16'd200;
      thresh_running   = 16'd2000;
      thresh_overload  = 16'd5000;
      crit_percent     = 8'd120;
      dry_timeout      = 16'd5000;
      overload_timeout = 16'd1000;
      pump_state       = ST_OFF;
      latched          = 1'b0;
      relay            = 1'b0;
      mismatches       = 0;
      clear_timers();
    endfunction

    function void clear_timers();
      armed      = '0;
      dry_start  = '0;
      crit_start = '0;
      ovl_start  = '0;
    endfunction

    function logic [31:0] crit_threshold();
      logic [31:0] prod;
      prod = thresh_running * crit_percent;
      return prod / CritScale;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_PUMP_MODE:      pump_mode        = data[0];
        CFG_THRESH_OFF:     thresh_off       = data;
        CFG_THRESH_NOWATER: thresh_no_water  = data;
        CFG_THRESH_RUNNING: thresh_running   = data;
        CFG_THRESH_OVL:     thresh_overload  = data;
        CFG_CRIT_PERCENT:   crit_percent     = data[7:0];
        CFG_DRY_TIMEOUT:    dry_timeout      = data;
        default:            overload_timeout = data;
      endcase
    endfunction

    // Arm on first qualifying sample; afterwards report whether it has expired.
    function bit timer_due(int unsigned which, logic [31:0] now, logic [15:0] limit);
      logic [31:0] start;
      if (!armed[which]) begin
        armed[which] = 1'b1;
        case (which)
          ARM_DRY:  dry_start  = now;
          ARM_CRIT: crit_start = now;
          default:  ovl_start  = now;
        endcase
        return 1'b0;
      end
      case (which)
        ARM_DRY:  start = dry_start;
        ARM_CRIT: start = crit_start;
        default:  start = ovl_start;
      endcase
      return (now - start) >= {16'd0, limit};
    endfunction

    function bit classify_sample(logic [15:0] cur, logic [31:0] now);
      logic [2:0] next;
      next = pump_state;
      if (latched) return 1'b0;
      if (cur < thresh_off) begin
        next  = ST_OFF;
        armed = '0;
      end else if (cur >= thresh_overload) begin
        if (timer_due(ARM_OVL, now, overload_timeout)) next = ST_OVL;
        armed = armed & (3'b001 << ARM_OVL);
      end else if (!pump_mode) begin
        next  = ST_RUN;
        armed = '0;
      end else if ({16'd0, cur} >= crit_threshold()) begin
        if (timer_due(ARM_CRIT, now, dry_timeout)) next = ST_CRIT;
        armed = armed & (3'b001 << ARM_CRIT);
      end else if (cur >= thresh_running) begin
        next  = ST_HIGH;
        armed = '0;
      end else if (cur < thresh_no_water) begin
        if (timer_due(ARM_DRY, now, dry_timeout)) next = ST_DRY;
        armed = armed & (3'b001 << ARM_DRY);
      end else begin
        next  = ST_RUN;
        armed = '0;
      end
      if (next == pump_state) return 1'b0;
      pump_state = next;
      latched    = (next == ST_OVL) || (next == ST_DRY) || (next == ST_CRIT);
      if (latched) relay = 1'b0;
      return 1'b1;
    endfunction

    function void note_input(in_item_t item);
      out_item_t status;
      bit        notify;
      notify = 1'b0;
      case (item.func)
        FUNC_SAMPLE: notify = classify_sample(item.current_ma, item.time_ms);
        FUNC_CLEAR: begin
          latched = 1'b0;
          clear_timers();
          if (pump_state == ST_DRY || pump_state == ST_CRIT || pump_state == ST_OVL) begin
            pump_state = ST_OFF;
            notify     = 1'b1;
          end
        end
        FUNC_ON, FUNC_OFF, FUNC_TOGGLE: begin
          if (item.func == FUNC_TOGGLE) relay = !relay;
          else relay = (item.func == FUNC_ON);
          latched = 1'b0;
          notify  = 1'b1;
        end
        FUNC_RESET: begin
          pump_state = ST_OFF;
          latched    = 1'b0;
          clear_timers();
        end
        default: ;
      endcase
      status.pump_state    = pump_state;
      status.relay_on      = relay;
      status.fault_latched = latched;
      status.event_res     = notify;
      expected_status.push_back(status);
    endfunction

    task report_mismatch(string what);
      $display("ERROR %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_status.size() == 0) begin
        report_mismatch($sformatf("status transfer %h with nothing expected", got));
        return;
      end
      want = expected_status.pop_front();
      if (got.pump_state !== want.pump_state)
        report_mismatch($sformatf("pump_state %0d, expected %0d",
                                  got.pump_state, want.pump_state));
      if (got.relay_on !== want.relay_on)
        report_mismatch($sformatf("relay_on %b, expected %b", got.relay_on, want.relay_on));
      if (got.fault_latched !== want.fault_latched)
        report_mismatch($sformatf("fault_latched %b, expected %b",
                                  got.fault_latched, want.fault_latched));
      if (got.event_res !== want.event_res)
        report_mismatch($sformatf("event_res %b, expected %b", got.event_res, want.event_res));
    endtask
  endclass

endpackage

[sim/tb_pump_current_fault_monitor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pump current fault monitor testbench
// Drives samples and commands through the monitor under random idling on
// both channels, across several register settings, and checks every status
// transfer against a scoreboard that predicts the monitor state.
// ----------------------------------------------------------------------------
module tb_pump_current_fault_monitor_unit;
  import pcfm_pkg::*;
  import pcfm_scoreboard_pkg::*;

  // func codes that the monitor must ignore
  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  // One register setting and the number of random items run under it
  typedef struct {
    logic        mode;
    logic [15:0] off;
    logic [15:0] no_water;
    logic [15:0] running;
    logic [15:0] overload;
    logic [7:0]  percent;
    logic [15:0] dry_to;
    logic [15:0] ovl_to;
    int unsigned items;
  } phase_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_idx   = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  pump_status_scoreboard sb;

  // Idling control: odds out of 16 that a burst starts, zero in calm stretches
  bit          calm       = 1'b0;
  int unsigned gap_odds   = 0;
  int unsigned stall_odds = 0;
  logic [31:0] now_ms     = '0;

  pump_current_fault_monitor_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard limit, far beyond the slowest correct run
  initial begin
    #(5_000_000);
    $display("FAIL pump_current_fault_monitor_unit");
    $finish;
  end

  // Check every status transfer; values seen here are the ones from before
  // the edge, so the order of processes within the step does not matter.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Result side backpressure: random stall bursts
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!calm && stall_odds != 0 && $urandom_range(1, 16) <= stall_odds) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Hold one item until its transfer, maybe after an idle burst, then note it.
  // Valid stays high from item to item unless a burst drops it first.
  task automatic send_item(in_item_t item);
    if (!calm && gap_odds != 0 && $urandom_range(1, 16) <= gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(item);
  endtask

  task automatic send_cmd(logic [2:0] func, logic [15:0] cur, logic [31:0] stamp);
    in_item_t item;
    item.func       = func;
    item.current_ma = cur;
    item.time_ms    = stamp;
    send_item(item);
  endtask

  // Drop valid and wait for every expected status; a leftover is caught later
  task automatic drain();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (sb.expected_status.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    // every item yields a result, so a short settle is plenty
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Write all eight registers; junk in the unused upper bits must be dropped
  task automatic program_regs(phase_t p);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(CFG_PUMP_MODE, {junk[15:1], p.mode});
    write_reg(CFG_THRESH_OFF, p.off);
    write_reg(CFG_THRESH_NOWATER, p.no_water);
    write_reg(CFG_THRESH_RUNNING, p.running);
    write_reg(CFG_THRESH_OVL, p.overload);
    junk = 16'($urandom);
    write_reg(CFG_CRIT_PERCENT, {junk[15:8], p.percent});
    write_reg(CFG_DRY_TIMEOUT, p.dry_to);
    write_reg(CFG_OVL_TIMEOUT, p.ovl_to);
    cfg_we <= 1'b0;
  endtask

  // Current for one sample: band 0..5 lies between adjacent thresholds,
  // band 6 is anything, bands 7..13 hug one threshold from either side.
  function automatic logic [15:0] pick_current(int unsigned band);
    logic [31:0] marks [7];
    logic [31:0] v;
    logic [31:0] d;
    marks[0] = 32'd0;
    marks[1] = 32'(sb.thresh_off);
    marks[2] = 32'(sb.thresh_no_water);
    marks[3] = 32'(sb.thresh_running);
    marks[4] = (sb.crit_threshold() > 32'hFFFF) ? 32'hFFFF : sb.crit_threshold();
    marks[5] = 32'(sb.thresh_overload);
    marks[6] = 32'hFFFF;
    if (band < 6) begin
      v = $urandom_range(marks[band], marks[band + 1]);
    end else if (band == 6) begin
      v = $urandom_range(0, 32'hFFFF);
    end else begin
      d = $urandom_range(0, 3);
      if ($urandom_range(0, 1)) v = marks[band - 7] + d;
      else v = (marks[band - 7] >= d) ? marks[band - 7] - d : 32'd0;
    end
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  // Time advance: mostly a fraction of the longest timeout, now and then more
  function automatic logic [31:0] pick_step();
    logic [31:0] longest;
    longest = (sb.dry_timeout > sb.overload_timeout) ? 32'(sb.dry_timeout)
                                                     : 32'(sb.overload_timeout);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2 * longest + 1);
    return $urandom_range(0, longest / 3 + 1);
  endfunction

  function automatic logic [2:0] pick_command();
    case ($urandom_range(0, 9))
      0, 1:    return FUNC_CLEAR;
      2, 3:    return FUNC_ON;
      4:       return FUNC_OFF;
      5, 6:    return FUNC_TOGGLE;
      7:       return FUNC_RESET;
      8:       return FUNC_SPARE_LO;
      default: return FUNC_SPARE_HI;
    endcase
  endfunction

  // Random part of one phase: runs of samples in one current band with
  // rising timestamps, so persistence timers can expire, mixed with commands
  // that clear latches and with jumps of the clock anywhere in its range.
  task automatic run_random(int unsigned items);
    int unsigned done;
    int unsigned band;
    int unsigned run_len;
    done = 0;
    while (done < items) begin
      if ($urandom_range(0, 3) == 0) begin
        send_cmd(pick_command(), 16'($urandom), $urandom);
        done++;
      end
      band    = $urandom_range(0, 13);
      run_len = $urandom_range(1, 10);
      repeat (run_len) begin
        if ($urandom_range(0, 39) == 0) now_ms = $urandom;
        else now_ms = now_ms + pick_step();
        send_cmd(FUNC_SAMPLE, pick_current(band), now_ms);
        done++;
      end
    end
  endtask

  initial begin
    phase_t plan [7];
    // phase 0 keeps the reset values and is never written
    plan[0] = '{1'b1, 16'd50, 16'd200, 16'd2000, 16'd5000, 8'd120, 16'd5000, 16'd1000, 200};
    plan[1] = '{1'b1, 16'd100, 16'd500, 16'd1500, 16'd4000, 8'd150, 16'd50, 16'd20, 250};
    plan[2] = '{1'b0, 16'd30, 16'd300, 16'd1000, 16'd3000, 8'd120, 16'd0, 16'd0, 150};
    plan[3] = '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 80};
    plan[4] = '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 150};
    plan[5] = '{1'b1, 16'd10, 16'd400, 16'd800, 16'd60000, 8'd0, 16'd30, 16'hFFFF, 150};
    plan[6] = '{1'b1, 16'd100, 16'd1000, 16'd3000, 16'd9000, 8'd100, 16'd200, 16'd100, 200};

    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset values: every command, each threshold edge,
    // persistence timers expiring, the latch ignoring samples, a fault state
    // that persists after re-enable, and an overload timed across the wrap.
    send_cmd(FUNC_SAMPLE, 16'd0, 32'd0);
    send_cmd(FUNC_ON, 16'd0, 32'd1);
    send_cmd(FUNC_SAMPLE, 16'd1000, 32'd10);
    send_cmd(FUNC_SAMPLE, 16'd2000, 32'd15);
    send_cmd(FUNC_SAMPLE, 16'd2400, 32'd20);
    send_cmd(FUNC_SAMPLE, 16'd2400, 32'd5020);
    send_cmd(FUNC_SAMPLE, 16'd1000, 32'd5030);
    send_cmd(FUNC_CLEAR, 16'd0, 32'd5040);
    send_cmd(FUNC_TOGGLE, 16'd0, 32'd5050);
    send_cmd(FUNC_SAMPLE, 16'd100, 32'd6000);
    send_cmd(FUNC_SAMPLE, 16'd100, 32'd11000);
    send_cmd(FUNC_ON, 16'd0, 32'd11005);
    send_cmd(FUNC_SAMPLE, 16'd100, 32'd11010);
    send_cmd(FUNC_SAMPLE, 16'hFFFF, 32'd20000);
    send_cmd(FUNC_SAMPLE, 16'hFFFF, 32'd21000);
    send_cmd(FUNC_OFF, 16'd0, 32'd21010);
    send_cmd(FUNC_RESET, 16'hFFFF, 32'd21020);
    send_cmd(FUNC_SPARE_LO, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(FUNC_SPARE_HI, 16'h0000, 32'h0000_0000);
    send_cmd(FUNC_SAMPLE, 16'd5000, 32'hFFFF_FF00);
    send_cmd(FUNC_SAMPLE, 16'd5000, 32'h0000_0300);
    send_cmd(FUNC_TOGGLE, 16'd0, 32'h0000_0310);
    send_cmd(FUNC_CLEAR, 16'd0, 32'h0000_0320);
    send_cmd(FUNC_SAMPLE, 16'd49, 32'h0000_0330);
    send_cmd(FUNC_SAMPLE, 16'd50, 32'h0000_0340);
    now_ms = 32'h0000_0400;

    for (int p = 0; p < 7; p++) begin
      if (p != 0) begin
        drain();
        program_regs(plan[p]);
      end
      // the last phase runs with no idling at all
      calm       = (p == 6);
      gap_odds   = $urandom_range(0, 6);
      stall_odds = $urandom_range(0, 6);
      // start one phase right below the wrap of the clock
      if (p == 4) now_ms = 32'hFFFF_0000;
      run_random(plan[p].items);
    end

    drain();
    if (sb.expected_status.size() != 0)
      sb.report_mismatch($sformatf("%0d status transfers never arrived",
                                   sb.expected_status.size()));
    if (sb.mismatches == 0) begin
      $display("PASS pump_current_fault_monitor_unit");
    end else begin
      $display("FAIL pump_current_fault_monitor_unit");
    end
    $finish;
  end

endmodule
